>>> hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helpers for the JSON string unescaper:
// decode modes, UTF-8 encoding and packing of output byte runs.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int RUN_BYTES = 8;
  localparam int RUN_W     = RUN_BYTES * 8;
  localparam int RUN_LEN_W = $clog2(RUN_BYTES + 1);

  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX     = 3'd2,
    MODE_WAIT_BS = 3'd3,
    MODE_WAIT_U  = 3'd4,
    MODE_LOW_HEX = 3'd5
  } mode_t;

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  // code point ranges
  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] CP_1B_MAX = 21'h7F;
  localparam logic [20:0] CP_2B_MAX = 21'h7FF;
  localparam logic [20:0] CP_3B_MAX = 21'hFFFF;

  // up to four bytes, first byte in the low bits
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } seg_t;

  // bytes caused by one request, first byte in the low bits
  typedef struct packed {
    logic [RUN_W-1:0]     bytes;
    logic [RUN_LEN_W-1:0] len;
  } run_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h = '0;
    if (b >= CH_0 && b <= CH_9) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CH_0);
    end else if (b >= CH_LA && b <= CH_LF) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CH_LA + 8'd10);
    end else if (b >= CH_UA && b <= CH_UF) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CH_UA + 8'd10);
    end
    return h;
  endfunction

  function automatic seg_t seg_byte(input logic [7:0] b);
    seg_t s;
    s.bytes = {24'h0, b};
    s.len   = 3'd1;
    return s;
  endfunction

  function automatic seg_t utf8(input logic [20:0] cp);
    seg_t s;
    priority if (cp <= CP_1B_MAX) begin
      s.bytes = {24'h0, cp[7:0]};
      s.len   = 3'd1;
    end else if (cp <= CP_2B_MAX) begin
      s.bytes = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      s.len   = 3'd2;
    end else if (cp <= CP_3B_MAX) begin
      s.bytes = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      s.len   = 3'd3;
    end else begin
      s.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
      s.len   = 3'd4;
    end
    return s;
  endfunction

  // hex digits held back, replayed oldest first
  function automatic seg_t seg_digits(input logic [2:0] cnt, input logic [23:0] raw);
    seg_t s;
    unique case (cnt)
      3'd0: begin
        s = '0;
      end
      3'd1: begin
        s.bytes = {24'h0, raw[7:0]};
        s.len   = 3'd1;
      end
      3'd2: begin
        s.bytes = {16'h0, raw[7:0], raw[15:8]};
        s.len   = 3'd2;
      end
      default: begin
        s.bytes = {8'h0, raw[7:0], raw[15:8], raw[23:16]};
        s.len   = 3'd3;
      end
    endcase
    return s;
  endfunction

  function automatic run_t run_append(input run_t r, input seg_t s);
    run_t             o;
    logic [RUN_W-1:0] wide;
    wide    = RUN_W'(s.bytes) << {r.len, 3'b000};
    o.bytes = r.bytes | wide;
    o.len   = r.len + RUN_LEN_W'(s.len);
    return o;
  endfunction

endpackage

>>> hw/rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder state and the single-pass logic that turns one input byte
// into the run of output bytes it causes.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc_i,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output jsu_pkg::run_t run_o
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic [15:0]    acc_r, acc_nxt;
  logic [23:0]    raw_r, raw_nxt;
  logic [15:0]    hi_r, hi_nxt;

  jsu_pkg::hex_t  hx;
  logic [15:0]    acc_add;
  logic [23:0]    raw_add;
  logic [2:0]     cnt_add;
  logic           dig_full;
  logic           is_high;
  logic           is_low;
  logic [20:0]    pair_cp;
  logic           is_bs;

  jsu_pkg::mode_t plain_mode;
  jsu_pkg::seg_t  plain_seg;
  jsu_pkg::mode_t esc_mode;
  jsu_pkg::seg_t  esc_seg;
  logic           esc_u;

  jsu_pkg::run_t  run;

  assign hx       = jsu_pkg::hex_value(in_byte);
  assign acc_add  = {acc_r[11:0], hx.val};
  assign raw_add  = {raw_r[15:0], in_byte};
  assign cnt_add  = cnt_r + 3'd1;
  assign dig_full = (cnt_add >= 3'd4);
  assign is_high  = (acc_add >= jsu_pkg::HIGH_MIN) && (acc_add <= jsu_pkg::HIGH_MAX);
  assign is_low   = (acc_add >= jsu_pkg::LOW_MIN) && (acc_add <= jsu_pkg::LOW_MAX);
  // surrogate pair: high and low offsets are the low ten bits of each half
  assign pair_cp  = jsu_pkg::SUPP_BASE + {1'b0, hi_r[9:0], acc_add[9:0]};
  assign is_bs    = (in_byte == jsu_pkg::CH_BSLASH);

  // byte handled as ordinary text
  always_comb begin
    if (is_bs) begin
      plain_mode = jsu_pkg::MODE_ESC;
      plain_seg  = '0;
    end else begin
      plain_mode = jsu_pkg::MODE_PLAIN;
      plain_seg  = jsu_pkg::seg_byte(in_byte);
    end
  end

  // byte following a backslash
  always_comb begin
    esc_mode = jsu_pkg::MODE_PLAIN;
    esc_u    = 1'b0;
    unique case (in_byte)
      jsu_pkg::CH_B: esc_seg = jsu_pkg::seg_byte(jsu_pkg::CTL_BS);
      jsu_pkg::CH_F: esc_seg = jsu_pkg::seg_byte(jsu_pkg::CTL_FF);
      jsu_pkg::CH_N: esc_seg = jsu_pkg::seg_byte(jsu_pkg::CTL_LF);
      jsu_pkg::CH_R: esc_seg = jsu_pkg::seg_byte(jsu_pkg::CTL_CR);
      jsu_pkg::CH_T: esc_seg = jsu_pkg::seg_byte(jsu_pkg::CTL_TAB);
      jsu_pkg::CH_U: begin
        esc_seg  = '0;
        esc_mode = jsu_pkg::MODE_HEX;
        esc_u    = 1'b1;
      end
      default: esc_seg = jsu_pkg::seg_byte(in_byte);
    endcase
  end

  always_comb begin
    run      = '0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    raw_nxt  = raw_r;
    hi_nxt   = hi_r;

    unique case (mode_r)
      jsu_pkg::MODE_ESC: begin
        run      = jsu_pkg::run_append(run, esc_seg);
        mode_nxt = esc_mode;
        if (esc_u) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          raw_nxt = '0;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hx.ok) begin
          run      = jsu_pkg::run_append(run, jsu_pkg::seg_digits(cnt_r, raw_r));
          run      = jsu_pkg::run_append(run, plain_seg);
          mode_nxt = plain_mode;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          raw_nxt  = '0;
        end else if (dig_full) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          raw_nxt = '0;
          if (is_high) begin
            hi_nxt   = acc_add;
            mode_nxt = jsu_pkg::MODE_WAIT_BS;
          end else begin
            run      = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(acc_add)));
            mode_nxt = jsu_pkg::MODE_PLAIN;
          end
        end else begin
          cnt_nxt = cnt_add;
          acc_nxt = acc_add;
          raw_nxt = raw_add;
        end
      end
      jsu_pkg::MODE_WAIT_BS: begin
        if (is_bs) begin
          mode_nxt = jsu_pkg::MODE_WAIT_U;
        end else begin
          run      = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(hi_r)));
          run      = jsu_pkg::run_append(run, plain_seg);
          mode_nxt = plain_mode;
        end
      end
      jsu_pkg::MODE_WAIT_U: begin
        if (in_byte == jsu_pkg::CH_U) begin
          mode_nxt = jsu_pkg::MODE_LOW_HEX;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          raw_nxt  = '0;
        end else begin
          // lone high surrogate, then the byte is an ordinary escape
          run      = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(hi_r)));
          run      = jsu_pkg::run_append(run, esc_seg);
          mode_nxt = esc_mode;
          if (esc_u) begin
            cnt_nxt = '0;
            acc_nxt = '0;
            raw_nxt = '0;
          end
        end
      end
      jsu_pkg::MODE_LOW_HEX: begin
        if (!hx.ok) begin
          run      = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(hi_r)));
          run      = jsu_pkg::run_append(run, jsu_pkg::seg_digits(cnt_r, raw_r));
          run      = jsu_pkg::run_append(run, plain_seg);
          mode_nxt = plain_mode;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          raw_nxt  = '0;
        end else if (dig_full) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          raw_nxt = '0;
          if (is_low) begin
            run      = jsu_pkg::run_append(run, jsu_pkg::utf8(pair_cp));
            mode_nxt = jsu_pkg::MODE_PLAIN;
          end else begin
            run = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(hi_r)));
            if (is_high) begin
              hi_nxt   = acc_add;
              mode_nxt = jsu_pkg::MODE_WAIT_BS;
            end else begin
              run      = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(acc_add)));
              mode_nxt = jsu_pkg::MODE_PLAIN;
            end
          end
        end else begin
          cnt_nxt = cnt_add;
          acc_nxt = acc_add;
          raw_nxt = raw_add;
        end
      end
      default: begin
        run      = jsu_pkg::run_append(run, plain_seg);
        mode_nxt = plain_mode;
      end
    endcase

    // end of string: flush whatever is still pending
    if (in_last) begin
      unique case (mode_nxt)
        jsu_pkg::MODE_HEX: begin
          run = jsu_pkg::run_append(run, jsu_pkg::seg_digits(cnt_nxt, raw_nxt));
        end
        jsu_pkg::MODE_WAIT_BS, jsu_pkg::MODE_WAIT_U: begin
          run = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(hi_nxt)));
        end
        jsu_pkg::MODE_LOW_HEX: begin
          run = jsu_pkg::run_append(run, jsu_pkg::utf8(21'(hi_nxt)));
          run = jsu_pkg::run_append(run, jsu_pkg::seg_digits(cnt_nxt, raw_nxt));
        end
        default: begin
        end
      endcase
      mode_nxt = jsu_pkg::MODE_PLAIN;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      raw_nxt  = '0;
      hi_nxt   = '0;
    end
  end

  assign run_o = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_PLAIN;
      cnt_r  <= '0;
      acc_r  <= '0;
      raw_r  <= '0;
      hi_r   <= '0;
    end else if (acc_i) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      raw_r  <= raw_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

>>> hw/rtl/jsu_emit.sv
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds the run of bytes for one request and shifts them
// out one per accepted result.
// ----------------------------------------------------------------------------
module jsu_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_i,
  input  jsu_pkg::run_t run_i,
  output logic          free_o,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_run_last
);

  logic [jsu_pkg::RUN_W-1:0]     bytes_r, bytes_nxt;
  logic [jsu_pkg::RUN_LEN_W-1:0] cnt_r, cnt_nxt;
  logic                          take;

  assign out_valid    = (cnt_r != '0);
  assign out_byte     = bytes_r[7:0];
  assign out_run_last = (cnt_r == jsu_pkg::RUN_LEN_W'(1));
  assign take         = out_valid && !out_stall;
  // room for a new run once the last byte of this one leaves
  assign free_o       = (cnt_r == '0) || (out_run_last && !out_stall);

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (load_i && run_i.len != '0) begin
      bytes_nxt = run_i.bytes;
      cnt_nxt   = run_i.len;
    end else if (take) begin
      bytes_nxt = bytes_r >> 8;
      cnt_nxt   = cnt_r - jsu_pkg::RUN_LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/json_string_unescape_utf8.sv
// The first result byte of a request is valid in the cycle after it is taken.
// Throughput: one input byte per cycle while each byte gives at most one result and
// the output does not stall; a byte giving several results holds the input until its
// last byte leaves, since the single result register drains one byte per accepted result.
// Reset: synchronous active-low rst_n returns the decoder to plain text and
// empties the result register.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes a JSON string body byte stream and emits the text as UTF-8,
// combining surrogate pairs and replaying malformed hex literally.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  logic          in_acc;
  logic          free;
  jsu_pkg::run_t run;

  assign in_stall = !free;
  assign in_acc   = in_valid && free;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_i   (in_acc),
    .in_byte (in_byte),
    .in_last (in_last),
    .run_o   (run)
  );

  jsu_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_i       (in_acc),
    .run_i        (run),
    .free_o       (free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  // no request ever produces more than seven bytes
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (run.len <= jsu_pkg::RUN_LEN_W'(7)))
    else $error("run longer than seven bytes");

  // a request with results shows its first byte next cycle
  a_run_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && run.len != '0) |=> out_valid)
    else $error("run not presented after request");

  // input only backs up behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  // last byte taken with nothing new loaded leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_last && !out_stall && !in_acc) |=> !out_valid)
    else $error("result register did not drain");

endmodule
